// File: rtl/cat_pkg.sv
// Shared types and constants for the closest approach time block.
package cat_pkg;

	localparam int COORD_W  = 24;
	localparam int TIME_W   = 64;
	localparam int SUM_W    = 56;
	localparam int EPS_W    = 32;
	localparam int MAX_AXES = 3;
	localparam int AXIS_W   = 2;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;
	localparam int DATA_W   = 4 * COORD_W + 2 * TIME_W;

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(42950);

	// One finished pair handed from the accumulator to the divider side.
	typedef struct packed {
		logic signed [SUM_W-1:0]  num;
		logic [SUM_W-1:0]         den;
		logic [TIME_W-1:0]        ts;
		logic [TIME_W-1:0]        te;
	} cat_entry_t;

	typedef struct packed {
		logic               valid;
		logic [QCNT_W-1:0]  count;
	} cat_qstat_t;

endpackage

// File: rtl/cat_queue.sv
// Short request queue between the accumulating front and the dividing back.
module cat_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cat_pkg::cat_entry_t push_data,
	input  logic               pop,
	output cat_pkg::cat_entry_t pop_data,
	output cat_pkg::cat_qstat_t stat
);
	import cat_pkg::*;

	cat_entry_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_pop;

	assign do_pop = pop && (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign stat.valid = (count_q != '0);
	assign stat.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/cat_front.sv
// Front end: takes axis requests, forms products and accumulates the sums per pair.
module cat_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cat_pkg::DATA_W-1:0] in_data,
	input  logic                       in_last,
	input  cat_pkg::cat_qstat_t        qstat,
	output logic                       push,
	output cat_pkg::cat_entry_t        push_data
);
	import cat_pkg::*;

	logic signed [COORD_W-1:0] p1, e1, p3, e3;
	logic [TIME_W-1:0]         ts_in, te_in;
	logic                      accept, eff_last;
	logic [AXIS_W-1:0]         axis_q;

	logic                      valid_s1, last_s1;
	logic signed [COORD_W:0]   diff_s1;
	logic signed [COORD_W+1:0] dd_s1;
	logic [TIME_W-1:0]         ts_s1, te_s1;

	logic                          valid_s2, last_s2;
	logic signed [2*COORD_W+2:0]   nprod_s2;
	logic signed [2*COORD_W+3:0]   dprod_s2;
	logic [TIME_W-1:0]             ts_s2, te_s2;

	logic signed [SUM_W-1:0]   num_sum_q, num_next;
	logic [SUM_W-1:0]          den_sum_q, den_next;
	logic [QCNT_W-1:0]         pending;

	assign p1    = in_data[COORD_W-1:0];
	assign e1    = in_data[2*COORD_W-1:COORD_W];
	assign p3    = in_data[3*COORD_W-1:2*COORD_W];
	assign e3    = in_data[4*COORD_W-1:3*COORD_W];
	assign ts_in = in_data[4*COORD_W+TIME_W-1:4*COORD_W];
	assign te_in = in_data[DATA_W-1:4*COORD_W+TIME_W];

	// Every pair still in the pipeline needs a queue slot waiting for it.
	assign pending  = qstat.count + QCNT_W'(valid_s1 && last_s1) + QCNT_W'(valid_s2 && last_s2);
	assign in_ready = (pending < QCNT_W'(QDEPTH));
	assign accept   = in_valid && in_ready;
	assign eff_last = in_last || (axis_q == AXIS_W'(MAX_AXES - 1));

	assign num_next = num_sum_q + SUM_W'(nprod_s2);
	assign den_next = den_sum_q + SUM_W'(dprod_s2);

	assign push           = valid_s2 && last_s2;
	assign push_data.num  = num_next;
	assign push_data.den  = den_next;
	assign push_data.ts   = ts_s2;
	assign push_data.te   = te_s2;

	always_ff @(posedge clk) begin
		diff_s1  <= (COORD_W+1)'(p3) - (COORD_W+1)'(p1);
		dd_s1    <= ((COORD_W+2)'(e1) - (COORD_W+2)'(p1)) - ((COORD_W+2)'(e3) - (COORD_W+2)'(p3));
		ts_s1    <= ts_in;
		te_s1    <= te_in;
		nprod_s2 <= (2*COORD_W+3)'(diff_s1) * (2*COORD_W+3)'(dd_s1);
		dprod_s2 <= (2*COORD_W+4)'(dd_s1) * (2*COORD_W+4)'(dd_s1);
		ts_s2    <= ts_s1;
		te_s2    <= te_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q    <= '0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
			valid_s2  <= 1'b0;
			last_s2   <= 1'b0;
			num_sum_q <= '0;
			den_sum_q <= '0;
		end else begin
			valid_s1 <= accept;
			last_s1  <= eff_last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			if (accept) begin
				axis_q <= eff_last ? '0 : axis_q + 1'b1;
			end
			if (valid_s2) begin
				num_sum_q <= last_s2 ? '0 : num_next;
				den_sum_q <= last_s2 ? '0 : den_next;
			end
		end
	end

endmodule

// File: rtl/cat_back.sv
// Back end: edge tests and the serial scaled division that yields the meet time.
module cat_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [cat_pkg::EPS_W-1:0]  cfg_wr_data,
	input  cat_pkg::cat_qstat_t        qstat,
	input  cat_pkg::cat_entry_t        entry,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_found,
	output logic [cat_pkg::TIME_W-1:0] out_time
);
	import cat_pkg::*;

	typedef enum logic [2:0] {IDLE, MUL_LO, MUL_HI, CHECK, DIV, DONE} state_t;

	localparam int HALF_W = SUM_W / 2;
	localparam int PROD_W = EPS_W + HALF_W;
	localparam int WIDE_W = EPS_W + SUM_W;

	state_t                  state_q;
	logic [EPS_W-1:0]        eps_q;
	logic signed [SUM_W-1:0] num_q;
	logic [SUM_W-1:0]        den_q;
	logic [TIME_W-1:0]       ts_q, mag_q, quo_q;
	logic                    back_q, bad_q;
	logic [PROD_W-1:0]       plo_q, phi_q;
	logic [SUM_W-1:0]        rem_q;
	logic [5:0]              cnt_q;

	logic                    entry_back, entry_bad;
	logic [WIDE_W-1:0]       epsden, num_wide, gap_wide;
	logic [SUM_W:0]          trial, den2;

	assign pop = (state_q == IDLE) && qstat.valid;

	assign entry_back = $signed(entry.te) < $signed(entry.ts);
	assign entry_bad  = (entry.den == '0) || entry.num[SUM_W-1] || (entry.num == '0)
		|| ($unsigned(entry.num) >= entry.den);

	// eps*den against num<<32 and (den-num)<<32 covers both ends of the interval.
	assign epsden   = {phi_q, {HALF_W{1'b0}}} + WIDE_W'(plo_q);
	assign num_wide = {$unsigned(num_q), {EPS_W{1'b0}}};
	assign gap_wide = {den_q - $unsigned(num_q), {EPS_W{1'b0}}};

	assign trial = {rem_q, 1'b0} + (mag_q[TIME_W-1] ? {1'b0, $unsigned(num_q)} : '0);
	assign den2  = {den_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			eps_q     <= EPS_RESET;
			out_valid <= 1'b0;
			out_found <= 1'b0;
			out_time  <= '0;
		end else begin
			if (cfg_wr_en) begin
				eps_q <= cfg_wr_data;
			end
			if (out_valid && out_ready && (state_q != DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (qstat.valid) begin
						num_q   <= entry.num;
						den_q   <= entry.den;
						ts_q    <= entry.ts;
						back_q  <= entry_back;
						mag_q   <= entry_back ? entry.ts - entry.te : entry.te - entry.ts;
						bad_q   <= entry_bad;
						state_q <= MUL_LO;
					end
				end
				MUL_LO: begin
					plo_q   <= PROD_W'(eps_q) * PROD_W'(den_q[HALF_W-1:0]);
					state_q <= MUL_HI;
				end
				MUL_HI: begin
					phi_q   <= PROD_W'(eps_q) * PROD_W'(den_q[SUM_W-1:HALF_W]);
					state_q <= CHECK;
				end
				CHECK: begin
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '1;
					if (bad_q || (num_wide <= epsden) || (gap_wide <= epsden)) begin
						bad_q   <= 1'b1;
						state_q <= DONE;
					end else begin
						state_q <= DIV;
					end
				end
				DIV: begin
					// One bit of the time span per cycle: remainder stays below den.
					if (trial >= den2) begin
						rem_q <= SUM_W'(trial - den2);
						quo_q <= {quo_q[TIME_W-2:0], 1'b0} + TIME_W'(2);
					end else if (trial >= {1'b0, den_q}) begin
						rem_q <= SUM_W'(trial - {1'b0, den_q});
						quo_q <= {quo_q[TIME_W-2:0], 1'b1};
					end else begin
						rem_q <= SUM_W'(trial);
						quo_q <= {quo_q[TIME_W-2:0], 1'b0};
					end
					mag_q <= {mag_q[TIME_W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_found <= !bad_q;
						out_time  <= bad_q ? '0 : (back_q ? ts_q - quo_q : ts_q + quo_q);
						state_q   <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/closest_approach_time.sv
// Top level of the closest approach time block.
// An axis request passes the s1 and s2 registers before it is added into the sums. The back end
// takes one pair at a time from the queue: capture, low and high multiply steps, edge tests,
// a divide step per bit of the time span (skipped for a rejected pair), then the output.
// Axis requests are taken one per cycle while the four-entry pair queue has room.
// Reset clears the sums, axis count, queue and output; edge_epsilon returns to 42950.
module closest_approach_time (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [cat_pkg::EPS_W-1:0]  cfg_wr_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// first_start_coord, first_end_coord, second_start_coord, second_end_coord,
	// interval_start, interval_end
	input  logic [cat_pkg::DATA_W-1:0] s_tdata,
	// last_axis
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// meet_time
	output logic [cat_pkg::TIME_W-1:0] m_tdata,
	// found
	output logic                       m_tuser
);
	import cat_pkg::*;

	logic        push, pop;
	cat_entry_t  push_data, pop_data;
	cat_qstat_t  qstat;

	cat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	cat_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (qstat)
	);

	cat_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.qstat       (qstat),
		.entry       (pop_data),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_found   (m_tuser),
		.out_time    (m_tdata)
	);

endmodule
